FILE: rtl/rlcl_pkg.sv
// shared constants and types of the rpm layer crossfade locator
package rlcl_pkg;

   // sizing of the breakpoint table and the fraction
   localparam int MAX_LAYERS     = 8;
   localparam int SPEED_BITS     = 16;
   localparam int FRACTION_BITS  = 16;
   localparam int LAYER_BITS     = $clog2(MAX_LAYERS);

   // fixed field and register widths
   localparam int SPEED_IN_BITS  = 16;
   localparam int LAYER_OUT_BITS = 3;
   localparam int FRAC_OUT_BITS  = 16;
   localparam int COUNT_BITS     = 4;
   localparam int BP_WIDTH       = 16;
   localparam int TABLE_BITS     = 64;
   localparam int BP_PER_WORD    = TABLE_BITS / BP_WIDTH;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LAYER_COUNT = 2'd0,
      CSR_TABLE_LOW   = 2'd1,
      CSR_TABLE_HIGH  = 2'd2
   } csr_index_type;

   // configuration held by the top level
   typedef struct packed {
      logic [COUNT_BITS-1:0] layer_count;
      logic [TABLE_BITS-1:0] table_low;
      logic [TABLE_BITS-1:0] table_high;
   } cfg_type;

   // request state travelling down the divider chain
   typedef struct packed {
      logic [LAYER_BITS-1:0]    lower;
      logic [LAYER_BITS-1:0]    upper;
      logic [SPEED_BITS-1:0]    rem;
      logic [SPEED_BITS-1:0]    div;
      logic [FRACTION_BITS-1:0] quot;
   } pipe_type;

endpackage

FILE: rtl/rlcl_channels.sv
// request and response channel interfaces
interface rlcl_req_if;
   logic                                valid;
   logic                                ready;
   logic [rlcl_pkg::SPEED_IN_BITS-1:0]  engine_speed;

   modport source (output valid, output engine_speed, input ready);
   modport sink   (input valid, input engine_speed, output ready);
endinterface

interface rlcl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rlcl_pkg::LAYER_OUT_BITS-1:0] lower_layer;
   logic [rlcl_pkg::LAYER_OUT_BITS-1:0] upper_layer;
   logic [rlcl_pkg::FRAC_OUT_BITS-1:0]  blend_fraction;

   modport source (output valid, output lower_layer, output upper_layer,
                   output blend_fraction, input ready);
   modport sink   (input valid, input lower_layer, input upper_layer,
                   input blend_fraction, output ready);
endinterface

FILE: rtl/rlcl_locate.sv
// head cell: finds the bracketing breakpoint pair and seeds the divider
module rlcl_locate (
   input  logic                               clock,
   input  logic                               reset,
   input  rlcl_pkg::cfg_type                  cfg,
   input  logic                               in_valid,
   input  logic [rlcl_pkg::SPEED_IN_BITS-1:0] engine_speed,
   output logic                               in_ready,
   input  logic                               out_ready,
   output logic                               out_valid,
   output rlcl_pkg::pipe_type                 out_data
);

   logic [rlcl_pkg::SPEED_BITS-1:0] bp [rlcl_pkg::MAX_LAYERS];
   logic [rlcl_pkg::SPEED_BITS-1:0] diff_x [rlcl_pkg::MAX_LAYERS-1];
   logic [rlcl_pkg::SPEED_BITS-1:0] diff_d [rlcl_pkg::MAX_LAYERS-1];
   logic [rlcl_pkg::MAX_LAYERS-2:0] hit;
   logic [rlcl_pkg::SPEED_BITS-1:0] speed;
   logic [rlcl_pkg::SPEED_BITS-1:0] bp_last;
   logic [rlcl_pkg::COUNT_BITS-1:0] n_eff;
   logic [rlcl_pkg::LAYER_BITS-1:0] last;
   logic [rlcl_pkg::LAYER_BITS-1:0] sel;
   logic                            valid_ff;
   logic                            valid_in;
   rlcl_pkg::pipe_type              data_ff;
   rlcl_pkg::pipe_type              data_in;

   // unpack breakpoints from the two table words
   for (genvar i = 0; i < rlcl_pkg::MAX_LAYERS; i++) begin : g_bp
      if (i < rlcl_pkg::BP_PER_WORD) begin : g_low
         assign bp[i] = cfg.table_low[(i % rlcl_pkg::BP_PER_WORD) * rlcl_pkg::BP_WIDTH
                                      +: rlcl_pkg::SPEED_BITS];
      end else begin : g_high
         assign bp[i] = cfg.table_high[(i % rlcl_pkg::BP_PER_WORD) * rlcl_pkg::BP_WIDTH
                                       +: rlcl_pkg::SPEED_BITS];
      end
   end

   // per-pair bracket test and differences, all in parallel
   for (genvar i = 0; i < rlcl_pkg::MAX_LAYERS - 1; i++) begin : g_pair
      assign hit[i]    = (rlcl_pkg::COUNT_BITS'(i + 1) < n_eff) &&
                         (speed >= bp[i]) && (speed < bp[i+1]);
      assign diff_x[i] = speed - bp[i];
      assign diff_d[i] = bp[i+1] - bp[i];
   end

   // effective count, last layer and lowest bracketing pair
   always_comb begin
      speed   = engine_speed[rlcl_pkg::SPEED_BITS-1:0];
      n_eff   = (cfg.layer_count > rlcl_pkg::COUNT_BITS'(rlcl_pkg::MAX_LAYERS)) ?
                rlcl_pkg::COUNT_BITS'(rlcl_pkg::MAX_LAYERS) : cfg.layer_count;
      last    = rlcl_pkg::LAYER_BITS'(n_eff - rlcl_pkg::COUNT_BITS'(1));
      bp_last = bp[last];
      sel     = '0;
      for (int i = rlcl_pkg::MAX_LAYERS - 2; i >= 0; i--) begin
         if (hit[i]) begin
            sel = rlcl_pkg::LAYER_BITS'(i);
         end
      end
   end

   // seed for the divider; out-of-range cases divide zero by one
   always_comb begin
      data_in       = data_ff;
      valid_in      = valid_ff;
      if (in_ready) begin
         valid_in      = in_valid;
         data_in.lower = '0;
         data_in.upper = '0;
         data_in.rem   = '0;
         data_in.div   = rlcl_pkg::SPEED_BITS'(1);
         data_in.quot  = '0;
         if ((n_eff <= rlcl_pkg::COUNT_BITS'(1)) || (speed <= bp[0])) begin
            data_in.lower = '0;
         end else if (speed >= bp_last) begin
            data_in.lower = last;
            data_in.upper = last;
         end else if (|hit) begin
            data_in.lower = sel;
            data_in.upper = sel + rlcl_pkg::LAYER_BITS'(1);
            data_in.rem   = diff_x[sel];
            data_in.div   = diff_d[sel];
         end else begin
            data_in.lower = last;
            data_in.upper = last;
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   // seed is either a proper pair or a zero fraction
   a_seed_shape: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((data_ff.upper == data_ff.lower) && (data_ff.rem == '0)) ||
                   ((data_ff.upper == data_ff.lower + rlcl_pkg::LAYER_BITS'(1)) &&
                    (data_ff.rem < data_ff.div)))
      else $error("locate seed out of shape");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.div != '0))
      else $error("locate seed has zero divisor");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> (valid_ff && $stable(data_ff)))
      else $error("locate stage lost a stalled request");

endmodule

FILE: rtl/rlcl_div_cell.sv
// one restoring-division cell: yields one fraction bit per stage
module rlcl_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rlcl_pkg::pipe_type in_data,
   output logic               in_ready,
   input  logic               out_ready,
   output logic               out_valid,
   output rlcl_pkg::pipe_type out_data
);

   logic [rlcl_pkg::SPEED_BITS:0] rem2;
   logic [rlcl_pkg::SPEED_BITS:0] trial;
   logic                          valid_ff;
   logic                          valid_in;
   rlcl_pkg::pipe_type            data_ff;
   rlcl_pkg::pipe_type            data_in;

   // shift remainder, try subtracting the divisor
   always_comb begin
      rem2  = {in_data.rem, 1'b0};
      trial = rem2 - {1'b0, in_data.div};
   end

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
         data_in  = in_data;
         if (rem2 >= {1'b0, in_data.div}) begin
            data_in.rem  = trial[rlcl_pkg::SPEED_BITS-1:0];
            data_in.quot = {in_data.quot[rlcl_pkg::FRACTION_BITS-2:0], 1'b1};
         end else begin
            data_in.rem  = rem2[rlcl_pkg::SPEED_BITS-1:0];
            data_in.quot = {in_data.quot[rlcl_pkg::FRACTION_BITS-2:0], 1'b0};
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.rem < data_ff.div))
      else $error("division remainder not below divisor");

   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (data_ff.upper == data_ff.lower)) |-> (data_ff.quot == '0))
      else $error("non-zero fraction on a single layer");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> (valid_ff && $stable(data_ff)))
      else $error("division cell lost a stalled request");

endmodule

FILE: rtl/rpm_layer_crossfade_locator.sv
// top level of the rpm layer crossfade locator
//
// Usage: write layer_count and the two breakpoint table words on the csr_
// port while the block is idle; breakpoints are 16-bit speeds, layer 0 in
// the low bits of the low word. Each request on req_chan carries one engine
// speed; each response on rsp_chan carries the lower and upper layer of the
// first breakpoint pair that brackets it and the upper layer's weight as an
// unsigned Q0.16 fraction, floor((speed - lo) * 65536 / (hi - lo)).
// Structure: one locate cell that does the parallel breakpoint compares, then
// a chain of 16 identical division cells, each producing one fraction bit;
// responses come from the last cell's register. Throughput is one request
// per cycle while rsp_chan takes responses; every cell holds one request.
// Back-pressure: each cell takes a new request whenever it is empty or its
// neighbour takes its contents, so bubbles close up and requests keep being
// accepted until the whole chain is full behind a stalled response.
// Reset: synchronous, active high; clears all configuration to zero and
// empties the chain.
module rpm_layer_crossfade_locator (
   input  logic                                clock,
   input  logic                                reset,
   rlcl_req_if.sink                            req_chan,
   rlcl_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [rlcl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rlcl_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   localparam int STAGES = rlcl_pkg::FRACTION_BITS;

   rlcl_pkg::cfg_type  cfg_ff;
   rlcl_pkg::cfg_type  cfg_in;
   logic               stage_valid [STAGES+1];
   logic               stage_ready [STAGES+1];
   rlcl_pkg::pipe_type stage_data  [STAGES+1];

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (rlcl_pkg::csr_index_type'(csr_index))
            rlcl_pkg::CSR_LAYER_COUNT: begin
               cfg_in.layer_count = csr_wr_data[rlcl_pkg::COUNT_BITS-1:0];
            end
            rlcl_pkg::CSR_TABLE_LOW: begin
               cfg_in.table_low = csr_wr_data[rlcl_pkg::TABLE_BITS-1:0];
            end
            rlcl_pkg::CSR_TABLE_HIGH: begin
               cfg_in.table_high = csr_wr_data[rlcl_pkg::TABLE_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // head cell
   rlcl_locate u_locate (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_chan.valid),
      .engine_speed (req_chan.engine_speed),
      .in_ready     (req_chan.ready),
      .out_ready    (stage_ready[0]),
      .out_valid    (stage_valid[0]),
      .out_data     (stage_data[0])
   );

   // chain of division cells
   for (genvar k = 0; k < STAGES; k++) begin : g_cell
      rlcl_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_data   (stage_data[k]),
         .in_ready  (stage_ready[k]),
         .out_ready (stage_ready[k+1]),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   // response from the last cell's register
   assign stage_ready[STAGES]     = rsp_chan.ready;
   assign rsp_chan.valid          = stage_valid[STAGES];
   assign rsp_chan.lower_layer    = rlcl_pkg::LAYER_OUT_BITS'(stage_data[STAGES].lower);
   assign rsp_chan.upper_layer    = rlcl_pkg::LAYER_OUT_BITS'(stage_data[STAGES].upper);
   assign rsp_chan.blend_fraction = rlcl_pkg::FRAC_OUT_BITS'(stage_data[STAGES].quot);

endmodule

FILE: dv/tb_rpm_layer_crossfade_locator.sv
// self-checking testbench for the rpm layer crossfade locator
`timescale 1ns / 100ps

module tb_rpm_layer_crossfade_locator;

   // run limits
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int IDLE_PERCENT = 26;
   localparam int REPORT_LIMIT = 10;

   // register index with no register behind it
   localparam logic [rlcl_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   // shapes of random breakpoint tables
   typedef enum int {TABLE_SPREAD, TABLE_TIGHT, TABLE_SCRAMBLED} table_style_type;

   // one located speed: bracketing layers and upper weight
   typedef struct packed {
      logic [rlcl_pkg::LAYER_OUT_BITS-1:0] lower;
      logic [rlcl_pkg::LAYER_OUT_BITS-1:0] upper;
      logic [rlcl_pkg::FRAC_OUT_BITS-1:0]  frac;
   } layer_blend_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic [rlcl_pkg::SPEED_IN_BITS-1:0]  req_speed = '0;
   logic                                rsp_ready = 1'b0;
   logic                                csr_wr_en = 1'b0;
   logic [rlcl_pkg::CSR_INDEX_BITS-1:0] csr_index = rlcl_pkg::CSR_LAYER_COUNT;
   logic [rlcl_pkg::CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   // shadow copy of the configuration
   logic [rlcl_pkg::COUNT_BITS-1:0] cfg_count      = '0;
   logic [rlcl_pkg::TABLE_BITS-1:0] cfg_table_low  = '0;
   logic [rlcl_pkg::TABLE_BITS-1:0] cfg_table_high = '0;

   logic [rlcl_pkg::SPEED_IN_BITS-1:0] speed_backlog[$];
   layer_blend_type                    blend_expected[$];
   int unsigned                        fault_count = 0;
   int unsigned                        cycle_count = 0;
   bit                                 calm_phase = 1'b0;

   rlcl_req_if req_bus ();
   rlcl_rsp_if rsp_bus ();

   assign req_bus.valid        = req_valid;
   assign req_bus.engine_speed = req_speed;
   assign rsp_bus.ready        = rsp_ready;

   rpm_layer_crossfade_locator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // breakpoint speed of one layer from the shadow table
   function automatic logic [rlcl_pkg::BP_WIDTH-1:0] breakpoint_at(input int unsigned idx);
      logic [rlcl_pkg::TABLE_BITS-1:0] word;
      word = (idx < rlcl_pkg::BP_PER_WORD) ? cfg_table_low : cfg_table_high;
      return word[(idx % rlcl_pkg::BP_PER_WORD) * rlcl_pkg::BP_WIDTH +: rlcl_pkg::BP_WIDTH];
   endfunction

   // bracketing layers and blend fraction for one speed
   function automatic layer_blend_type locate_speed(
      input logic [rlcl_pkg::SPEED_IN_BITS-1:0] speed);
      int unsigned                   n;
      int unsigned                   i;
      logic [rlcl_pkg::BP_WIDTH-1:0] lo;
      logic [rlcl_pkg::BP_WIDTH-1:0] hi;
      logic [47:0]                   ratio;
      layer_blend_type               r;
      bit                            found;
      n = (cfg_count > rlcl_pkg::MAX_LAYERS) ? rlcl_pkg::MAX_LAYERS : cfg_count;
      r = '0;
      if (n <= 1 || speed <= breakpoint_at(0)) begin
         return r;
      end
      r.lower = rlcl_pkg::LAYER_OUT_BITS'(n - 1);
      r.upper = rlcl_pkg::LAYER_OUT_BITS'(n - 1);
      if (speed >= breakpoint_at(n - 1)) begin
         return r;
      end
      // first ascending pair that brackets the speed wins
      found = 1'b0;
      for (i = 0; i + 1 < n; i++) begin
         lo = breakpoint_at(i);
         hi = breakpoint_at(i + 1);
         if (!found && speed >= lo && speed < hi) begin
            ratio   = (48'(speed - lo) << rlcl_pkg::FRACTION_BITS) / 48'(hi - lo);
            r.lower = rlcl_pkg::LAYER_OUT_BITS'(i);
            r.upper = rlcl_pkg::LAYER_OUT_BITS'(i + 1);
            r.frac  = ratio[rlcl_pkg::FRAC_OUT_BITS-1:0];
            found   = 1'b1;
         end
      end
      return r;
   endfunction

   // count a fault and report the first few
   task automatic flag_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   // register write, shadowed once the block has taken it
   task automatic csr_write(input logic [rlcl_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [rlcl_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         rlcl_pkg::CSR_LAYER_COUNT: cfg_count      = value[rlcl_pkg::COUNT_BITS-1:0];
         rlcl_pkg::CSR_TABLE_LOW:   cfg_table_low  = value;
         rlcl_pkg::CSR_TABLE_HIGH:  cfg_table_high = value;
         default: ;
      endcase
   endtask

   // layer count write with noise in the unused upper bits
   task automatic write_count(input int unsigned n);
      logic [rlcl_pkg::CSR_DATA_BITS-1:0] word;
      word = {$urandom(), $urandom()};
      word[rlcl_pkg::COUNT_BITS-1:0] = rlcl_pkg::COUNT_BITS'(n);
      csr_write(rlcl_pkg::CSR_LAYER_COUNT, word);
   endtask

   // wait until every request has been answered
   task automatic wait_drained;
      do begin
         @(negedge clock);
      end while (speed_backlog.size() != 0 || req_valid || blend_expected.size() != 0);
   endtask

   // one random table setting followed by a burst of speeds
   task automatic run_random_phase(input int items, input bit split_half);
      int unsigned  pts[rlcl_pkg::MAX_LAYERS];
      int unsigned  tmp;
      int unsigned  n;
      int unsigned  span_lo;
      int unsigned  span_hi;
      int           j;
      int           k;
      int           pick;
      table_style_type style;
      logic [rlcl_pkg::SPEED_IN_BITS-1:0] speed;
      style = table_style_type'($urandom_range(0, 2));
      for (j = 0; j < rlcl_pkg::MAX_LAYERS; j++) begin
         if (style == TABLE_TIGHT) begin
            if (j == 0) begin
               pts[j] = $urandom_range(0, 60000);
            end else begin
               pts[j] = pts[j-1] + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 700));
            end
            if (pts[j] > 65535) pts[j] = 65535;
         end else begin
            pts[j] = $urandom_range(0, 65535);
         end
      end
      // ascending order for the spread tables
      if (style == TABLE_SPREAD) begin
         for (j = 1; j < rlcl_pkg::MAX_LAYERS; j++) begin
            tmp = pts[j];
            k = j - 1;
            while (k >= 0 && pts[k] > tmp) begin
               pts[k+1] = pts[k];
               k--;
            end
            pts[k+1] = tmp;
         end
         if ($urandom_range(0, 3) == 0) pts[rlcl_pkg::MAX_LAYERS-1] = 65535;
      end
      if (style != TABLE_SCRAMBLED && $urandom_range(0, 3) == 0) pts[0] = 0;
      csr_write(rlcl_pkg::CSR_TABLE_LOW,
                {16'(pts[3]), 16'(pts[2]), 16'(pts[1]), 16'(pts[0])});
      csr_write(rlcl_pkg::CSR_TABLE_HIGH,
                {16'(pts[7]), 16'(pts[6]), 16'(pts[5]), 16'(pts[4])});
      if ($urandom_range(0, 3) == 0) csr_write(CSR_SPARE, {$urandom(), $urandom()});
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(2, rlcl_pkg::MAX_LAYERS)
                                     : $urandom_range(0, 15);
      write_count(n);
      // span of the breakpoints in use, for speeds that land inside the table
      span_lo = pts[0];
      span_hi = pts[0];
      for (j = 1; j < rlcl_pkg::MAX_LAYERS && j < n; j++) begin
         if (pts[j] < span_lo) span_lo = pts[j];
         if (pts[j] > span_hi) span_hi = pts[j];
      end
      for (k = 0; k < items; k++) begin
         if (split_half && k == items / 2) wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            speed = rlcl_pkg::SPEED_IN_BITS'($urandom_range(span_lo, span_hi));
         end else if (pick < 75) begin
            speed = rlcl_pkg::SPEED_IN_BITS'(pts[$urandom_range(0, rlcl_pkg::MAX_LAYERS - 1)]
                                             + $urandom_range(0, 2) - 1);
         end else begin
            speed = rlcl_pkg::SPEED_IN_BITS'($urandom());
         end
         speed_backlog.push_back(speed);
      end
      wait_drained();
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && req_bus.ready) begin
            blend_expected.push_back(locate_speed(req_speed));
            offer = 1'b0;
         end
         if (!offer && speed_backlog.size() != 0 &&
             (calm_phase || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_speed <= speed_backlog.pop_front();
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : rsp_monitor
      layer_blend_type got;
      layer_blend_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            got.lower = rsp_bus.lower_layer;
            got.upper = rsp_bus.upper_layer;
            got.frac  = rsp_bus.blend_fraction;
            if (blend_expected.size() == 0) begin
               flag_fault($sformatf("unexpected response %0d/%0d frac %0d",
                                    got.lower, got.upper, got.frac));
            end else begin
               want = blend_expected.pop_front();
               if (got.lower !== want.lower || got.upper !== want.upper ||
                   got.frac !== want.frac) begin
                  flag_fault($sformatf("mismatch: expected %0d/%0d frac %0d, got %0d/%0d frac %0d",
                                       want.lower, want.upper, want.frac,
                                       got.lower, got.upper, got.frac));
               end
            end
         end
         rsp_ready <= calm_phase || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // test sequence
   initial begin : sequencer
      int p;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: no layers
      speed_backlog.push_back(16'd0);
      speed_backlog.push_back(16'd65535);
      wait_drained();

      // evenly spaced eight-layer table
      csr_write(rlcl_pkg::CSR_TABLE_LOW, {16'd4000, 16'd3000, 16'd2000, 16'd1000});
      csr_write(rlcl_pkg::CSR_TABLE_HIGH, {16'd8000, 16'd7000, 16'd6000, 16'd5000});
      write_count(8);
      speed_backlog.push_back(16'd0);
      speed_backlog.push_back(16'd1000);
      speed_backlog.push_back(16'd1500);
      speed_backlog.push_back(16'd1999);
      speed_backlog.push_back(16'd2000);
      speed_backlog.push_back(16'd4500);
      speed_backlog.push_back(16'd7999);
      speed_backlog.push_back(16'd8000);
      speed_backlog.push_back(16'd65535);
      wait_drained();

      // single layer, then a count above the table size
      write_count(1);
      speed_backlog.push_back(16'd5000);
      wait_drained();
      write_count(15);
      speed_backlog.push_back(16'd7500);
      speed_backlog.push_back(16'd9000);
      wait_drained();

      // write to the spare index leaves the table alone
      csr_write(CSR_SPARE, {$urandom(), $urandom()});
      speed_backlog.push_back(16'd2500);
      wait_drained();

      // fewer layers in use than programmed
      write_count(3);
      speed_backlog.push_back(16'd3000);
      speed_backlog.push_back(16'd2999);
      wait_drained();

      // breakpoints at both ends of the speed range
      csr_write(rlcl_pkg::CSR_TABLE_LOW, {32'hFFFF_FFFF, 16'hFFFF, 16'h0000});
      write_count(2);
      speed_backlog.push_back(16'd1);
      speed_backlog.push_back(16'd32768);
      speed_backlog.push_back(16'd65534);
      wait_drained();

      // low word all zero, high word all ones
      csr_write(rlcl_pkg::CSR_TABLE_LOW, 64'h0);
      csr_write(rlcl_pkg::CSR_TABLE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_count(8);
      speed_backlog.push_back(16'd100);
      speed_backlog.push_back(16'd0);
      wait_drained();

      // table out of order
      csr_write(rlcl_pkg::CSR_TABLE_LOW, {16'd1000, 16'd5000, 16'd3000, 16'd2000});
      write_count(4);
      speed_backlog.push_back(16'd4000);
      speed_backlog.push_back(16'd1500);
      speed_backlog.push_back(16'd6000);
      wait_drained();

      // random settings, one with no idling and one paused halfway
      for (p = 0; p < 8; p++) begin
         calm_phase = (p == 3);
         run_random_phase(200, p == 5);
      end
      calm_phase = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0 && blend_expected.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
